// File: rtl/rtsm_pkg.sv
// Shared types and constants for the three-wire RTC serial master.
package rtsm_pkg;

  // Depth of each of the two item queues.
  localparam int QUEUE_DEPTH = 2;

  // Field widths.
  localparam int ACTION_W = 2;
  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;

  // Input actions.
  localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_TICKS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BCD_CONVERT = 1'b1;

  // Configuration reset values.
  localparam logic [BYTE_W-1:0] DELAY_TICKS_RST = 8'd1;
  localparam logic              BCD_CONVERT_RST = 1'b1;

  // Classified input item passed from the front to the back.
  typedef struct packed {
    logic               start;
    logic               is_read;
    logic [BYTE_W-1:0]  command;
    logic [BYTE_W-1:0]  write_data;
    logic [COUNT_W-1:0] read_count;
    logic               io_sample;
  } item_t;

  // Result item with the pin levels after one tick.
  typedef struct packed {
    logic              chip_enable;
    logic              serial_clock;
    logic              data_out;
    logic              data_drive;
    logic [BYTE_W-1:0] read_byte;
    logic              read_valid;
    logic              read_last;
    logic              busy_res;
  } result_t;

  // Converts a packed BCD byte to binary: high nibble times ten plus low nibble.
  function automatic logic [BYTE_W-1:0] from_bcd(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] hi;
    logic [BYTE_W-1:0] lo;
    hi = {4'd0, b[7:4]};
    lo = {4'd0, b[3:0]};
    return (hi << 3) + (hi << 1) + lo;
  endfunction

endpackage

// File: rtl/rtsm_fifo.sv
// Small first-in first-out queue of items with a registered count.
module rtsm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = rtsm_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  // Storage is written at the tail; no reset is needed for payload.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers wrap at the depth; the count tracks occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/rtsm_front.sv
// Front end: classifies each incoming tick item and queues it for the sequencer.
module rtsm_front #(
  parameter int QUEUE_DEPTH = rtsm_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [rtsm_pkg::ACTION_W-1:0] action,
  input  logic [rtsm_pkg::BYTE_W-1:0]   command,
  input  logic [rtsm_pkg::BYTE_W-1:0]   write_data,
  input  logic [rtsm_pkg::COUNT_W-1:0]  read_count,
  input  logic                          io_sample,
  input  logic                          item_pop,
  output rtsm_pkg::item_t               item,
  output logic                          item_empty
);

  rtsm_pkg::item_t                  classified;
  logic [$bits(rtsm_pkg::item_t)-1:0] q_out;

  // Decode the action; an unknown code is a plain tick and a zero count means one byte.
  always_comb begin
    classified.start      = (action == rtsm_pkg::ACT_WRITE) || (action == rtsm_pkg::ACT_READ);
    classified.is_read    = (action == rtsm_pkg::ACT_READ);
    classified.command    = command;
    classified.write_data = write_data;
    classified.read_count = (read_count == '0) ? rtsm_pkg::COUNT_W'(1) : read_count;
    classified.io_sample  = io_sample;
  end

  // Queue between the front and the sequencer.
  rtsm_fifo #(
    .WIDTH($bits(rtsm_pkg::item_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(classified),
    .full     (full),
    .pop      (item_pop),
    .pop_data (q_out),
    .empty    (item_empty)
  );

  assign item = rtsm_pkg::item_t'(q_out);

endmodule

// File: rtl/rtsm_back.sv
// Back end: the pin sequencer, the configuration registers and the result queue.
module rtsm_back #(
  parameter int QUEUE_DEPTH = rtsm_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  rtsm_pkg::item_t                item,
  input  logic                           item_empty,
  output logic                           item_pop,
  input  logic                           cfg_write,
  input  logic [rtsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rtsm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           pop,
  output logic                           empty,
  output rtsm_pkg::result_t              result
);

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_CE_LOW   = 4'd1,
    PH_SCK_LOW  = 4'd2,
    PH_CE_HIGH  = 4'd3,
    PH_W_LEAD   = 4'd4,
    PH_W_SETUP  = 4'd5,
    PH_W_HIGH   = 4'd6,
    PH_R_LEAD   = 4'd7,
    PH_R_SETUP  = 4'd8,
    PH_R_HIGH   = 4'd9,
    PH_END_LOW  = 4'd10,
    PH_END_HIGH = 4'd11
  } phase_t;

  localparam int BW = rtsm_pkg::BYTE_W;
  localparam int CNW = rtsm_pkg::COUNT_W;

  // Configuration.
  logic [BW-1:0] delay_ticks;
  logic          bcd_convert;

  // Sequencer state.
  phase_t        phase;
  logic          is_read;
  logic [BW-1:0] shift_reg;
  logic [BW-1:0] pending_data;
  logic [2:0]    bit_count;
  logic [CNW-1:0] bytes_left;
  logic [BW-1:0] delay_count;

  phase_t         phase_next;
  logic           is_read_next;
  logic [BW-1:0]  shift_reg_next;
  logic [BW-1:0]  pending_data_next;
  logic [2:0]     bit_count_next;
  logic [CNW-1:0] bytes_left_next;
  logic [BW-1:0]  delay_count_next;

  logic [BW-1:0]  limit;
  logic [BW-1:0]  dc_inc;
  logic [2:0]     bc_inc;
  logic [CNW-1:0] bl_dec;
  logic           out_full;
  logic           fire;
  rtsm_pkg::result_t res;
  logic [$bits(rtsm_pkg::result_t)-1:0] q_out;

  // One tick is carried out whenever an item waits and the result queue has room.
  assign fire     = !item_empty && !out_full;
  assign item_pop = fire;

  assign limit  = (delay_ticks == '0) ? BW'(1) : delay_ticks;
  assign dc_inc = delay_count + 1'b1;
  assign bc_inc = bit_count + 1'b1;
  assign bl_dec = bytes_left - 1'b1;

  // Configuration registers take writes at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ticks <= rtsm_pkg::DELAY_TICKS_RST;
      bcd_convert <= rtsm_pkg::BCD_CONVERT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rtsm_pkg::CFG_DELAY_TICKS: delay_ticks <= cfg_data;
        rtsm_pkg::CFG_BCD_CONVERT: bcd_convert <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Next state and the result of one tick.
  always_comb begin
    phase_next        = phase;
    is_read_next      = is_read;
    shift_reg_next    = shift_reg;
    pending_data_next = pending_data;
    bit_count_next    = bit_count;
    bytes_left_next   = bytes_left;
    delay_count_next  = delay_count;
    res               = '0;

    if (phase == PH_IDLE) begin
      // A start request loads the transaction; anything else is a plain tick.
      if (item.start) begin
        is_read_next      = item.is_read;
        shift_reg_next    = item.command;
        pending_data_next = item.write_data;
        bit_count_next    = '0;
        bytes_left_next   = item.is_read ? item.read_count : CNW'(1);
        delay_count_next  = '0;
        phase_next        = PH_CE_LOW;
      end
    end else begin
      delay_count_next = dc_inc;
      if (dc_inc >= limit) begin
        delay_count_next = '0;
        unique case (phase)
          PH_CE_LOW:  phase_next = PH_SCK_LOW;
          PH_SCK_LOW: phase_next = PH_CE_HIGH;
          PH_CE_HIGH: phase_next = PH_W_LEAD;
          PH_W_LEAD:  phase_next = PH_W_SETUP;
          PH_W_SETUP: phase_next = PH_W_HIGH;
          PH_W_HIGH: begin
            shift_reg_next = {1'b0, shift_reg[BW-1:1]};
            bit_count_next = bc_inc;
            if (bc_inc != '0) begin
              phase_next = PH_W_LEAD;
            end else if (is_read) begin
              phase_next     = PH_R_LEAD;
              shift_reg_next = '0;
            end else if (bytes_left != '0) begin
              bytes_left_next = '0;
              shift_reg_next  = pending_data;
              phase_next      = PH_W_LEAD;
            end else begin
              phase_next = PH_END_LOW;
            end
          end
          PH_R_LEAD:  phase_next = PH_R_SETUP;
          PH_R_SETUP: begin
            shift_reg_next = {item.io_sample, shift_reg[BW-1:1]};
            phase_next     = PH_R_HIGH;
          end
          PH_R_HIGH: begin
            bit_count_next = bc_inc;
            if (bc_inc != '0) begin
              phase_next = PH_R_SETUP;
            end else begin
              res.read_byte   = bcd_convert ? rtsm_pkg::from_bcd(shift_reg) : shift_reg;
              res.read_valid  = 1'b1;
              res.read_last   = (bl_dec == '0);
              bytes_left_next = bl_dec;
              shift_reg_next  = '0;
              phase_next      = (bl_dec == '0) ? PH_END_LOW : PH_R_LEAD;
            end
          end
          PH_END_LOW: phase_next = PH_END_HIGH;
          default:    phase_next = PH_IDLE;
        endcase
      end
    end

    // Pin levels after the tick follow the new phase.
    unique case (phase_next)
      PH_CE_HIGH, PH_R_LEAD, PH_R_SETUP, PH_END_LOW: begin
        res.chip_enable = 1'b1;
      end
      PH_W_LEAD, PH_W_SETUP: begin
        res.chip_enable = 1'b1;
        res.data_drive  = 1'b1;
        res.data_out    = shift_reg_next[0];
      end
      PH_W_HIGH: begin
        res.chip_enable  = 1'b1;
        res.serial_clock = 1'b1;
        res.data_drive   = 1'b1;
        res.data_out     = shift_reg_next[0];
      end
      PH_R_HIGH, PH_END_HIGH: begin
        res.chip_enable  = 1'b1;
        res.serial_clock = 1'b1;
      end
      default: ;
    endcase
    res.busy_res = (phase_next != PH_IDLE);
  end

  // Sequencer state advances once per carried-out tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      is_read      <= 1'b0;
      shift_reg    <= '0;
      pending_data <= '0;
      bit_count    <= '0;
      bytes_left   <= '0;
      delay_count  <= '0;
    end else if (fire) begin
      phase        <= phase_next;
      is_read      <= is_read_next;
      shift_reg    <= shift_reg_next;
      pending_data <= pending_data_next;
      bit_count    <= bit_count_next;
      bytes_left   <= bytes_left_next;
      delay_count  <= delay_count_next;
    end
  end

  // Result queue toward the receiver.
  rtsm_fifo #(
    .WIDTH($bits(rtsm_pkg::result_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_result_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (fire),
    .push_data(res),
    .full     (out_full),
    .pop      (pop),
    .pop_data (q_out),
    .empty    (empty)
  );

  assign result = rtsm_pkg::result_t'(q_out);

endmodule

// File: rtl/three_wire_rtc_serial_master_core.sv
// Top level of the three-wire RTC serial master.
//
// Each input item is one timing tick, optionally carrying a start request
// (action write or read) with the command byte, the write byte and the read
// byte count, plus the level sampled on the data pin. Items enter through a
// queue port: push is taken when full is low. Every item yields exactly one
// result item with the pin levels (enable, clock, data and its drive) after
// that tick, and on the tick that completes a received byte the byte itself,
// BCD-converted when enabled, with its valid and last-of-burst flags.
// Results leave through a queue port: the oldest result is shown while empty
// is low and is taken when pop is high.
// A result enters the result queue after its item has left the input queue through the sequencer.
// One item is carried out per cycle while the result queue has room, by the tick
// sequencer between a two-entry input queue and a two-entry result queue.
// When the receiver stops popping, the result queue fills, the sequencer
// holds, the input queue fills and full rises; nothing is lost.
// Synchronous reset empties both queues, returns the sequencer to idle and
// sets delay_ticks to one and BCD conversion on. The user must write configuration
// through cfg_write, cfg_index and cfg_data while the block is idle; it is not enforced.
module three_wire_rtc_serial_master_core #(
  parameter int QUEUE_DEPTH = rtsm_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  // Input item channel.
  input  logic                            push,
  output logic                            full,
  input  logic [rtsm_pkg::ACTION_W-1:0]   action,
  input  logic [rtsm_pkg::BYTE_W-1:0]     command,
  input  logic [rtsm_pkg::BYTE_W-1:0]     write_data,
  input  logic [rtsm_pkg::COUNT_W-1:0]    read_count,
  input  logic                            io_sample,
  // Result item channel.
  output logic                            empty,
  input  logic                            pop,
  output logic                            chip_enable,
  output logic                            serial_clock,
  output logic                            data_out,
  output logic                            data_drive,
  output logic [rtsm_pkg::BYTE_W-1:0]     read_byte,
  output logic                            read_valid,
  output logic                            read_last,
  output logic                            busy_res,
  // Configuration write port.
  input  logic                            cfg_write,
  input  logic [rtsm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rtsm_pkg::CFG_DATA_W-1:0] cfg_data
);

  rtsm_pkg::item_t   item;
  logic              item_empty;
  logic              item_pop;
  rtsm_pkg::result_t result;

  // Front: classify and queue incoming items.
  rtsm_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .action    (action),
    .command   (command),
    .write_data(write_data),
    .read_count(read_count),
    .io_sample (io_sample),
    .item_pop  (item_pop),
    .item      (item),
    .item_empty(item_empty)
  );

  // Back: run the pin sequence and queue results.
  rtsm_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .item_empty(item_empty),
    .item_pop  (item_pop),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

  // Result fields onto their ports.
  assign chip_enable  = result.chip_enable;
  assign serial_clock = result.serial_clock;
  assign data_out     = result.data_out;
  assign data_drive   = result.data_drive;
  assign read_byte    = result.read_byte;
  assign read_valid   = result.read_valid;
  assign read_last    = result.read_last;
  assign busy_res     = result.busy_res;

endmodule
